FILE: rtl/midi_to_usb_midi_packet_macros.svh
// Assertion macros for the checker file of the packet encoder
`ifndef MIDI_TO_USB_MIDI_PACKET_MACROS_SVH
`define MIDI_TO_USB_MIDI_PACKET_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high
`define MTUM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising clock edge, reset included
`define MTUM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: rtl/mtum_pkg.sv
// Constants, types and classification functions of the USB-MIDI packet encoder
package mtum_pkg;

   // Sysex framing bytes
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // Code index numbers
   localparam logic [3:0] CIN_NONE       = 4'h0;
   localparam logic [3:0] CIN_CABLE_EVT  = 4'h1;
   localparam logic [3:0] CIN_SYS_TWO    = 4'h2;
   localparam logic [3:0] CIN_SYS_THREE  = 4'h3;
   localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
   localparam logic [3:0] CIN_SINGLE_END = 4'h5;
   localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
   localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
   localparam logic [3:0] CIN_CHAN_FIRST = 4'h8;
   localparam logic [3:0] CIN_CHAN_LAST  = 4'hE;
   localparam logic [3:0] CIN_PROG_CHG   = 4'hC;
   localparam logic [3:0] CIN_CHAN_PRESS = 4'hD;
   localparam logic [3:0] CIN_SINGLE     = 4'hF;

   // Result status
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CABLE   = 2'd1,
      STATUS_BAD_MESSAGE = 2'd2
   } status_type;

   // Code index from the three-byte window; CIN_NONE when nothing matches
   function automatic logic [3:0] classify_cin(input logic [7:0] b0,
                                               input logic [7:0] b1,
                                               input logic [7:0] b2);
      logic       d0;
      logic       d1;
      logic       d2;
      logic [3:0] cin;
      d0  = ~b0[7];
      d1  = ~b1[7];
      d2  = ~b2[7];
      cin = CIN_NONE;
      if (b0[7:4] >= CIN_CHAN_FIRST && b0[7:4] <= CIN_CHAN_LAST) begin
         cin = b0[7:4];
      end else begin
         case (b0) inside
            8'hF1, 8'hF3: cin = CIN_SYS_TWO;
            8'hF2: cin = CIN_SYS_THREE;
            8'hF6: cin = CIN_SINGLE_END;
            8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: cin = CIN_SINGLE;
            SYSEX_START: begin
               if (b1 == SYSEX_END) begin
                  cin = CIN_SYSEX_END2;
               end else if (d1 && b2 == SYSEX_END) begin
                  cin = CIN_SYSEX_END3;
               end else if (d1 && d2) begin
                  cin = CIN_SYSEX_CONT;
               end
            end
            SYSEX_END: cin = CIN_SINGLE_END;
            default: begin
               // data byte leading: sysex continuation or tail
               if (d0) begin
                  if (d1 && d2) begin
                     cin = CIN_SYSEX_CONT;
                  end else if (d1 && b2 == SYSEX_END) begin
                     cin = CIN_SYSEX_END3;
                  end else if (!d1 && b1 == SYSEX_END) begin
                     cin = CIN_SYSEX_END2;
                  end
               end
            end
         endcase
      end
      return cin;
   endfunction

   // Number of MIDI bytes carried for a code index
   function automatic logic [1:0] length_of_cin(input logic [3:0] cin);
      logic [1:0] len;
      case (cin) inside
         CIN_NONE, CIN_CABLE_EVT: len = 2'd0;
         CIN_SINGLE_END, CIN_SINGLE: len = 2'd1;
         CIN_SYS_TWO, CIN_SYSEX_END2, CIN_PROG_CHG, CIN_CHAN_PRESS: len = 2'd2;
         default: len = 2'd3;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/mtum_req_if.sv
// Input channel: a three-byte MIDI window and its cable number
interface mtum_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_midi_byte;
   logic [7:0] second_midi_byte;
   logic [7:0] third_midi_byte;
   logic [7:0] cable_number;

   modport source (output valid, first_midi_byte, second_midi_byte, third_midi_byte,
                   cable_number, input ready);
   modport sink (input valid, first_midi_byte, second_midi_byte, third_midi_byte,
                 cable_number, output ready);
endinterface

FILE: rtl/mtum_rsp_if.sv
// Result channel: one USB-MIDI event packet with length and status
interface mtum_rsp_if;
   import mtum_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic [7:0] packet_byte_one;
   logic [7:0] packet_byte_two;
   logic [7:0] packet_byte_three;
   logic [1:0] message_length;
   status_type status_code;

   modport source (output valid, header_byte, packet_byte_one, packet_byte_two,
                   packet_byte_three, message_length, status_code, input ready);
   modport sink (input valid, header_byte, packet_byte_one, packet_byte_two,
                 packet_byte_three, message_length, status_code, output ready);
endinterface

FILE: rtl/midi_to_usb_midi_packet.sv
// Top level of the MIDI to USB-MIDI event packet encoder
//
//   channel    dir   handshake      word
//   req_chan   in    valid/ready    three MIDI bytes, cable number
//   rsp_chan   out   valid/ready    header, three packet bytes, length, status
//
// One word in per clock unless rsp_chan stalls; each result is offered on rsp_chan
// after its word has passed the input register and then the result register.
// Throughput is one word per cycle while rsp_chan.ready stays high; while a
// finished result waits, the input register takes one more word, then ready drops.
// Synchronous active-high reset empties both registers; no result is lost or
// repeated across a stall on either side.
module midi_to_usb_midi_packet (
   input logic      clock,
   input logic      reset,
   mtum_req_if.sink req_chan,
   mtum_rsp_if.source rsp_chan
);
   import mtum_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_b0_ff;
   logic [7:0] in_b1_ff;
   logic [7:0] in_b2_ff;
   logic [7:0] in_cable_ff;

   // result register
   logic       out_valid_ff;
   logic [7:0] out_header_ff, out_header_in;
   logic [7:0] out_one_ff, out_one_in;
   logic [7:0] out_two_ff, out_two_in;
   logic [7:0] out_three_ff, out_three_in;
   logic [1:0] out_len_ff, out_len_in;
   status_type out_status_ff, out_status_in;

   logic       out_load;
   logic       in_load;
   logic [3:0] cin;
   logic [1:0] len;

   // handshake: each register takes a word when empty or draining
   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign in_load        = !in_valid_ff || out_load;
   assign req_chan.ready = in_load;

   // classify and pack the registered window
   always_comb begin
      cin           = classify_cin(in_b0_ff, in_b1_ff, in_b2_ff);
      len           = length_of_cin(cin);
      out_header_in = 8'h00;
      out_one_in    = 8'h00;
      out_two_in    = 8'h00;
      out_three_in  = 8'h00;
      out_len_in    = 2'd0;
      out_status_in = STATUS_OK;
      if (in_cable_ff[7:4] != 4'h0) begin
         out_status_in = STATUS_BAD_CABLE;
      end else if (len == 2'd0) begin
         out_status_in = STATUS_BAD_MESSAGE;
      end else begin
         out_header_in = {in_cable_ff[3:0], cin};
         out_one_in    = in_b0_ff;
         out_two_in    = (len >= 2'd2) ? in_b1_ff : 8'h00;
         out_three_in  = (len == 2'd3) ? in_b2_ff : 8'h00;
         out_len_in    = len;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_load && req_chan.valid) begin
         in_b0_ff    <= req_chan.first_midi_byte;
         in_b1_ff    <= req_chan.second_midi_byte;
         in_b2_ff    <= req_chan.third_midi_byte;
         in_cable_ff <= req_chan.cable_number;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
      if (out_load && in_valid_ff) begin
         out_header_ff <= out_header_in;
         out_one_ff    <= out_one_in;
         out_two_ff    <= out_two_in;
         out_three_ff  <= out_three_in;
         out_len_ff    <= out_len_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.header_byte       = out_header_ff;
   assign rsp_chan.packet_byte_one   = out_one_ff;
   assign rsp_chan.packet_byte_two   = out_two_ff;
   assign rsp_chan.packet_byte_three = out_three_ff;
   assign rsp_chan.message_length    = out_len_ff;
   assign rsp_chan.status_code       = out_status_ff;

endmodule

FILE: rtl/mtum_checker.sv
// Port-level checks of the packet encoder and their bind to the top level
`include "midi_to_usb_midi_packet_macros.svh"

module mtum_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_header,
   input logic [7:0] rsp_one,
   input logic [7:0] rsp_two,
   input logic [7:0] rsp_three,
   input logic [1:0] rsp_len,
   input logic [1:0] rsp_status
);
   import mtum_pkg::*;

   // a stalled result stays offered
   `MTUM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // no result right after reset
   `MTUM_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result offered after reset")

   // error results carry an all-zero packet
   `MTUM_ASSERT(a_error_zero,
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_header == 8'h00 && rsp_one == 8'h00 && rsp_two == 8'h00 &&
         rsp_three == 8'h00 && rsp_len == 2'd0,
      "error result with nonzero packet")

   // good results carry a real code index and padding past the length
   `MTUM_ASSERT(a_ok_packet,
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_len != 2'd0 && rsp_header[3:0] != CIN_NONE &&
         (rsp_len == 2'd3 || rsp_three == 8'h00) &&
         (rsp_len != 2'd1 || rsp_two == 8'h00),
      "good result with bad length or padding")

endmodule

bind midi_to_usb_midi_packet mtum_checker u_mtum_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_header (rsp_chan.header_byte),
   .rsp_one    (rsp_chan.packet_byte_one),
   .rsp_two    (rsp_chan.packet_byte_two),
   .rsp_three  (rsp_chan.packet_byte_three),
   .rsp_len    (rsp_chan.message_length),
   .rsp_status (rsp_chan.status_code)
);

FILE: verif/mtum_packet_check.sv
// Scoreboard for the USB-MIDI packet encoder: predicts every packet and compares it
`timescale 1ns / 1ps
module mtum_packet_check
   import mtum_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mtum_req_if  req_chan,
   mtum_rsp_if  rsp_chan,
   output int   fail_count,
   output int   words_in_flight,
   output int   packets_checked,
   output int   ok_count,
   output int   bad_cable_count,
   output int   bad_message_count
);

   typedef struct packed {
      logic [7:0] header;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [1:0] length;
      status_type status;
   } usb_packet_type;

   // System common and real-time status bytes with a code index of their own
   localparam logic [7:0] MTC_QUARTER  = 8'hF1;
   localparam logic [7:0] SONG_POS     = 8'hF2;
   localparam logic [7:0] SONG_SELECT  = 8'hF3;
   localparam logic [7:0] TUNE_REQUEST = 8'hF6;
   localparam logic [7:0] TIMING_CLOCK = 8'hF8;
   localparam logic [7:0] SEQ_START    = 8'hFA;
   localparam logic [7:0] SEQ_CONTINUE = 8'hFB;
   localparam logic [7:0] SEQ_STOP     = 8'hFC;
   localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
   localparam logic [7:0] SYS_RESET    = 8'hFF;

   usb_packet_type expected_packets[$];

   int n_fail     = 0;
   int n_checked  = 0;
   int n_ok       = 0;
   int n_bad_cab  = 0;
   int n_bad_msg  = 0;
   int n_pending  = 0;

   assign fail_count        = n_fail;
   assign words_in_flight   = n_pending;
   assign packets_checked   = n_checked;
   assign ok_count          = n_ok;
   assign bad_cable_count   = n_bad_cab;
   assign bad_message_count = n_bad_msg;

   // Packet that one MIDI window on one cable should turn into
   function automatic usb_packet_type encode_usb_midi(input logic [7:0] b0,
                                                      input logic [7:0] b1,
                                                      input logic [7:0] b2,
                                                      input logic [7:0] cable);
      usb_packet_type pkt;
      logic [3:0]     cin;
      logic [1:0]     len;
      pkt        = '0;
      pkt.status = STATUS_OK;
      cin        = CIN_NONE;
      // cable range is judged before the bytes are looked at
      if (cable > 8'd15) begin
         pkt.status = STATUS_BAD_CABLE;
         return pkt;
      end
      if (b0[7] && b0[7:4] != 4'hF) begin
         // channel voice: the status nibble is the code index
         cin = b0[7:4];
      end else begin
         case (b0)
            MTC_QUARTER, SONG_SELECT: cin = CIN_SYS_TWO;
            SONG_POS: cin = CIN_SYS_THREE;
            TUNE_REQUEST, SYSEX_END: cin = CIN_SINGLE_END;
            TIMING_CLOCK, SEQ_START, SEQ_CONTINUE, SEQ_STOP, ACTIVE_SENSE, SYS_RESET:
               cin = CIN_SINGLE;
            default: begin
               // sysex: start byte or data leads, data follows, end byte may close
               if (b0 == SYSEX_START || !b0[7]) begin
                  if (b1 == SYSEX_END) begin
                     cin = CIN_SYSEX_END2;
                  end else if (!b1[7] && b2 == SYSEX_END) begin
                     cin = CIN_SYSEX_END3;
                  end else if (!b1[7] && !b2[7]) begin
                     cin = CIN_SYSEX_CONT;
                  end
               end
            end
         endcase
      end
      case (cin)
         CIN_NONE: len = 2'd0;
         CIN_SINGLE_END, CIN_SINGLE: len = 2'd1;
         CIN_SYS_TWO, CIN_SYSEX_END2, CIN_PROG_CHG, CIN_CHAN_PRESS: len = 2'd2;
         default: len = 2'd3;
      endcase
      if (len == 2'd0) begin
         pkt.status = STATUS_BAD_MESSAGE;
         return pkt;
      end
      pkt.header     = {cable[3:0], cin};
      pkt.byte_one   = b0;
      pkt.byte_two   = (len >= 2'd2) ? b1 : 8'h00;
      pkt.byte_three = (len == 2'd3) ? b2 : 8'h00;
      pkt.length     = len;
      return pkt;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %02h, actual %02h", name, want, got);
         n_fail++;
      end
   endtask

   // Queue a prediction per accepted window, compare each packet word taken
   always @(posedge clock) begin
      usb_packet_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            expected_packets.push_back(encode_usb_midi(req_chan.first_midi_byte,
                                                       req_chan.second_midi_byte,
                                                       req_chan.third_midi_byte,
                                                       req_chan.cable_number));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_checked++;
            if (expected_packets.size() == 0) begin
               $error("packet word with no window outstanding, header %02h",
                      rsp_chan.header_byte);
               n_fail++;
            end else begin
               want = expected_packets.pop_front();
               check_field("header_byte", want.header, rsp_chan.header_byte);
               check_field("packet_byte_one", want.byte_one, rsp_chan.packet_byte_one);
               check_field("packet_byte_two", want.byte_two, rsp_chan.packet_byte_two);
               check_field("packet_byte_three", want.byte_three, rsp_chan.packet_byte_three);
               check_field("message_length", {6'd0, want.length},
                           {6'd0, rsp_chan.message_length});
               check_field("status_code", {6'd0, want.status}, {6'd0, rsp_chan.status_code});
               case (want.status)
                  STATUS_OK: n_ok++;
                  STATUS_BAD_CABLE: n_bad_cab++;
                  default: n_bad_msg++;
               endcase
            end
         end
         n_pending = expected_packets.size();
      end
   end

endmodule

FILE: verif/tb.sv
// Testbench top for the USB-MIDI packet encoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
   import mtum_pkg::*;

   localparam int CYCLE_LIMIT       = 200000;
   localparam int WORDS_PER_PROFILE = 380;
   localparam int LONG_STALL_CYCLES = 80;

   logic clock;
   logic reset;

   mtum_req_if req_chan ();
   mtum_rsp_if rsp_chan ();

   int fail_count;
   int words_in_flight;
   int packets_checked;
   int ok_count;
   int bad_cable_count;
   int bad_message_count;

   int words_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit stall_request = 1'b0;

   logic [7:0] system_bytes[10] = '{8'hF1, 8'hF2, 8'hF3, 8'hF6, 8'hF8,
                                   8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF};

   midi_to_usb_midi_packet dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mtum_packet_check packet_check (
      .clock             (clock),
      .reset             (reset),
      .req_chan          (req_chan),
      .rsp_chan          (rsp_chan),
      .fail_count        (fail_count),
      .words_in_flight   (words_in_flight),
      .packets_checked   (packets_checked),
      .ok_count          (ok_count),
      .bad_cable_count   (bad_cable_count),
      .bad_message_count (bad_message_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            hold_left     = LONG_STALL_CYCLES;
            stall_request = 1'b0;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] any_data();
      return 8'($urandom_range(127));
   endfunction

   // a status byte that cannot close a sysex message
   function automatic logic [7:0] any_status_but_end();
      logic [7:0] s;
      s = 8'($urandom_range(255, 128));
      return (s == SYSEX_END) ? SYSEX_START : s;
   endfunction

   // Offer one word from a falling edge; returns at the falling edge after it is taken
   task automatic send_word(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] cable);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.first_midi_byte  <= b0;
      req_chan.second_midi_byte <= b1;
      req_chan.third_midi_byte  <= b2;
      req_chan.cable_number     <= cable;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      words_sent++;
   endtask

   // Mostly well-formed messages and sysex pieces, some broken, some raw noise
   task automatic send_random_word();
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] cable;
      int         pick;
      pick  = $urandom_range(99);
      b0    = 8'($urandom);
      b1    = 8'($urandom);
      b2    = 8'($urandom);
      cable = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 16)) : 8'($urandom_range(15));
      if (pick < 28) begin
         b0 = {4'($urandom_range(14, 8)), 4'($urandom)};
      end else if (pick < 42) begin
         b0 = system_bytes[$urandom_range(9)];
      end else if (pick < 80) begin
         case ($urandom_range(6))
            0: begin b0 = SYSEX_START; b1 = SYSEX_END; end
            1: begin b0 = SYSEX_START; b1 = any_data(); b2 = SYSEX_END; end
            2: begin b0 = SYSEX_START; b1 = any_data(); b2 = any_data(); end
            3: begin b0 = any_data(); b1 = any_data(); b2 = any_data(); end
            4: begin b0 = any_data(); b1 = any_data(); b2 = SYSEX_END; end
            5: begin b0 = any_data(); b1 = SYSEX_END; end
            default: b0 = SYSEX_END;
         endcase
      end else if (pick < 90) begin
         // broken sysex: a status byte where data or the end byte belongs
         b0 = ($urandom_range(1) == 0) ? SYSEX_START : any_data();
         if ($urandom_range(1) == 0) begin
            b1 = any_status_but_end();
         end else begin
            b1 = any_data();
            b2 = any_status_but_end();
         end
      end
      send_word(b0, b1, b2, cable);
   endtask

   // Stimulus and verdict
   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.first_midi_byte  = 8'h00;
      req_chan.second_midi_byte = 8'h00;
      req_chan.third_midi_byte  = 8'h00;
      req_chan.cable_number     = 8'h00;
      send_idle_pct             = 9;
      recv_idle_pct             = 62;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // channel voice, cable extremes; program change drops its third byte
      send_word(8'h80, 8'h00, 8'h7F, 8'd0);
      send_word(8'hC5, 8'h12, 8'h34, 8'd15);
      send_word(8'hD0, 8'h55, 8'h66, 8'd1);
      send_word(8'hEF, 8'h7F, 8'hFF, 8'd15);
      // every system common and real-time byte with a code index
      foreach (system_bytes[i]) send_word(system_bytes[i], 8'h5A, 8'hA5, 8'(i));
      // undefined status bytes
      send_word(8'hF4, 8'h00, 8'h00, 8'd2);
      send_word(8'hFD, 8'h11, 8'h22, 8'd3);
      // sysex start, body and tail shapes
      send_word(SYSEX_START, SYSEX_END, 8'h33, 8'd4);
      send_word(SYSEX_START, 8'h12, SYSEX_END, 8'd5);
      send_word(SYSEX_START, 8'h7F, 8'h00, 8'd6);
      send_word(8'h01, 8'h02, 8'h03, 8'd7);
      send_word(8'h7F, 8'h7F, SYSEX_END, 8'd8);
      send_word(8'h00, SYSEX_END, 8'h55, 8'd9);
      send_word(SYSEX_END, 8'h12, 8'h34, 8'd10);
      // broken sysex: status byte where data belongs
      send_word(SYSEX_START, 8'h12, 8'h90, 8'd11);
      send_word(8'h22, 8'h81, SYSEX_END, 8'd12);
      // bad cable wins over a good message and over a bad one
      send_word(8'h90, 8'h40, 8'h40, 8'd16);
      send_word(8'hF4, 8'h80, 8'h80, 8'hFF);

      for (int profile = 0; profile < 3; profile++) begin
         case (profile)
            0: begin send_idle_pct = 9; recv_idle_pct = 62; end
            1: begin send_idle_pct = 62; recv_idle_pct = 9; end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // result side holds off while words keep coming
               stall_request = 1'b1;
            end
         endcase
         repeat (WORDS_PER_PROFILE) send_random_word();
      end
      req_chan.valid <= 1'b0;

      while (words_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb: %0d words sent, %0d packets checked (%0d ok, %0d bad cable, %0d bad message)",
               words_sent, packets_checked, ok_count, bad_cable_count, bad_message_count);
      $display("tb: idle mixes sender/receiver 9/62, 62/9, 0/0 and one %0d-cycle result stall",
               LONG_STALL_CYCLES);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: midi_to_usb_midi_packet.f
+incdir+rtl
rtl/mtum_pkg.sv
rtl/mtum_req_if.sv
rtl/mtum_rsp_if.sv
rtl/midi_to_usb_midi_packet.sv
rtl/mtum_checker.sv
verif/mtum_packet_check.sv
verif/tb.sv
